### rtl/core/escaped_frame_decoder_macros.svh
// Assertion macros for the escaped frame decoder.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ESCAPED_FRAME_DECODER_MACROS_SVH
`define ESCAPED_FRAME_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Check an expression at every clock edge outside reset.
`define EFD_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define EFD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EFD_ASSERT(name, clk, rst_n, expr, msg)
`define EFD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/efd_pkg.sv
// Shared types and constants of the escaped frame decoder.
// No dependencies; used by the channel interfaces and the top level.
package efd_pkg;

    localparam logic [7:0] START_BYTE = 8'h7D;
    localparam logic [7:0] END_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7F;
    localparam logic [7:0] ESC_MAX    = 8'h02;
    localparam logic [7:0] HDR1_MASK  = 8'hF0;
    localparam logic [7:0] HDR2_MASK  = 8'h3F;

    localparam int POS_W = 11;
    localparam int LEN_W = 10;
    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FRAMING  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_is_status;
        logic [1:0]       out_status;
        logic [LEN_W-1:0] out_length;
        logic             out_last;
    } t_result;

endpackage

### rtl/core/efd_channels.sv
// Valid/ready channel interfaces for the escaped frame decoder.
// Depends on efd_pkg for the length width.
interface efd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface efd_out_if import efd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             out_is_status;
    logic [1:0]       out_status;
    logic [LEN_W-1:0] out_length;
    logic             out_last;

    modport source (output valid, output out_byte, output out_is_status, output out_status,
                    output out_length, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_is_status, input out_status,
                    input out_length, input out_last, output ready);
endinterface

### rtl/core/escaped_frame_decoder.sv
// Escaped frame decoder top level: deframing, unstuffing, checksum, result queue.
// Depends on efd_pkg, efd_channels and escaped_frame_decoder_macros.svh.
//
//  channel | dir | payload                                          | transfer
//  i_in    | in  | in_byte, in_last                                 | valid & ready
//  o_out   | out | out_byte, out_is_status, out_status, out_length,  | valid & ready
//          |     | out_last                                         |
//
// One raw byte is taken per cycle while input ready is high; it is decoded in the same cycle and its
// results (zero, one or two) land in a four-entry result queue.
// The queue sends one result per cycle while the output is ready, so a byte that yields two results
// needs an output transfer for each; input ready drops while fewer than two slots are free.
// A stalled output holds the queue head; input stalls while three or more results wait.
// Synchronous active-low reset clears frame state and empties the queue.
`include "escaped_frame_decoder_macros.svh"

module escaped_frame_decoder import efd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    efd_in_if.sink     i_in,
    efd_out_if.source  o_out
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // frame state
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_start, n_start;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_esc, n_esc;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_held_byte, n_held_byte;
    logic [7:0]       r_sum, n_sum;
    logic [LEN_W-1:0] r_count, n_count;

    // result queue
    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_qcnt, n_qcnt;

    logic       acc, pop;
    logic [7:0] b;
    logic       last;

    // decoded pushes for a body byte
    logic       p1v, p2v;
    logic [7:0] p1b, p2b;

    // emitted results
    logic       e1v, e2v;
    logic [7:0] e1b, e2b;
    logic       flush;
    logic       hv_f;
    logic [7:0] hb_f;
    logic [7:0] sum_f;
    logic [LEN_W-1:0] count_f;
    logic [LEN_W:0]   count_ext;
    logic [1:0]       n_emit;
    logic [POS_W:0]   total;
    logic [POS_W:0]   need;
    logic             frame_ok;
    logic [1:0]       status;

    t_result res0, res1;
    logic    res0_v, res1_v;
    logic [1:0] n_push;

    assign b    = i_in.in_byte;
    assign last = i_in.in_last;
    assign acc  = i_in.valid & i_in.ready;
    assign pop  = o_out.valid & o_out.ready;

    assign i_in.ready = (r_qcnt <= QCNT_W'(QDEPTH - 2));

    always_comb begin
        p1v = 1'b0;
        p2v = 1'b0;
        p1b = b;
        p2b = b;
        n_esc = r_esc;
        if (r_esc) begin
            n_esc = 1'b0;
            p1v   = 1'b1;
            if (b <= ESC_MAX) begin
                p1b = START_BYTE + b;
            end else begin
                p1b = ESC_BYTE;
                if (b == ESC_BYTE) begin
                    n_esc = 1'b1;
                end else begin
                    p2v = 1'b1;
                end
            end
        end else if (b == ESC_BYTE) begin
            n_esc = 1'b1;
        end else begin
            p1v = 1'b1;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_start      = r_start;
        n_len        = r_len;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_sum        = r_sum;
        n_count      = r_count;
        e1v   = 1'b0;
        e2v   = 1'b0;
        e1b   = r_held_byte;
        e2b   = p1b;
        flush = last & r_esc;
        hv_f  = r_held_valid;
        hb_f  = r_held_byte;
        res0   = '0;
        res1   = '0;
        res0_v = 1'b0;
        res1_v = 1'b0;
        status = ST_OK;
        frame_ok = 1'b0;

        if (last) begin
            // flush a pending raw escape, then close the frame
            e1v  = flush & r_held_valid;
            hv_f = r_held_valid | flush;
            hb_f = flush ? ESC_BYTE : r_held_byte;
        end else if (r_pos == '0) begin
            n_start = (b == START_BYTE);
        end else if (r_pos == POS_W'(1)) begin
            n_len = {(b & HDR1_MASK), 2'b00};
        end else if (r_pos == POS_W'(2)) begin
            n_len = r_len | LEN_W'(b & HDR2_MASK);
        end else begin
            e1v = p1v & r_held_valid;
            e2v = p2v;
            if (p1v) begin
                hv_f = 1'b1;
                hb_f = p2v ? p2b : p1b;
            end
        end

        sum_f     = r_sum + (e1v ? e1b : 8'h00) + (e2v ? e2b : 8'h00);
        n_emit    = {1'b0, e1v} + {1'b0, e2v};
        count_ext = {1'b0, r_count} + (LEN_W + 1)'(n_emit);
        count_f   = count_ext[LEN_W] ? COUNT_MAX : count_ext[LEN_W-1:0];

        total = {1'b0, r_pos} + (POS_W + 1)'(1);
        need  = (POS_W + 1)'(r_len) + (POS_W + 1)'(4);
        frame_ok = (r_pos != POS_MAX) && (total > (POS_W + 1)'(4)) && (total == need)
                   && r_start && (b == END_BYTE);
        if (!frame_ok) begin
            status = ST_FRAMING;
        end else if (!hv_f || (sum_f != hb_f)) begin
            status = ST_CHECKSUM;
        end

        // compact the emitted results into queue slots
        if (e1v) begin
            res0.out_byte = e1b;
            res0_v = 1'b1;
        end else if (e2v) begin
            res0.out_byte = e2b;
            res0_v = 1'b1;
        end
        if (e1v && e2v) begin
            res1.out_byte = e2b;
            res1_v = 1'b1;
        end
        if (last) begin
            if (res0_v) begin
                res1.out_is_status = 1'b1;
                res1.out_status    = status;
                res1.out_length    = count_f;
                res1.out_last      = 1'b1;
                res1_v = 1'b1;
            end else begin
                res0.out_is_status = 1'b1;
                res0.out_status    = status;
                res0.out_length    = count_f;
                res0.out_last      = 1'b1;
                res0_v = 1'b1;
            end
        end

        if (last) begin
            n_pos        = '0;
            n_start      = 1'b0;
            n_len        = '0;
            n_held_valid = 1'b0;
            n_held_byte  = '0;
            n_sum        = '0;
            n_count      = '0;
        end else begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
            n_held_valid = hv_f;
            n_held_byte  = hb_f;
            n_sum        = sum_f;
            n_count      = count_f;
        end
    end

    assign n_push = acc ? ({1'b0, res0_v} + {1'b0, res1_v}) : 2'd0;
    assign n_qcnt = r_qcnt + QCNT_W'(n_push) - QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_start      <= 1'b0;
            r_len        <= '0;
            r_esc        <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
            r_sum        <= '0;
            r_count      <= '0;
        end else if (acc) begin
            r_pos        <= n_pos;
            r_start      <= n_start;
            r_len        <= n_len;
            r_esc        <= last ? 1'b0 : (r_pos >= POS_W'(3)) ? n_esc : r_esc;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_sum        <= n_sum;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            r_wr   <= r_wr + QPTR_W'(n_push);
            r_rd   <= r_rd + QPTR_W'(pop);
            r_qcnt <= n_qcnt;
        end
    end

    // payload storage: no reset needed
    always_ff @(posedge i_clk) begin
        if (acc && res0_v) begin
            r_q[r_wr] <= res0;
        end
        if (acc && res1_v) begin
            r_q[r_wr + QPTR_W'(1)] <= res1;
        end
    end

    assign o_out.valid         = (r_qcnt != '0);
    assign o_out.out_byte      = r_q[r_rd].out_byte;
    assign o_out.out_is_status = r_q[r_rd].out_is_status;
    assign o_out.out_status    = r_q[r_rd].out_status;
    assign o_out.out_length    = r_q[r_rd].out_length;
    assign o_out.out_last      = r_q[r_rd].out_last;

    `EFD_ASSERT(a_queue_bound, i_clk, i_rst_n, r_qcnt <= QCNT_W'(QDEPTH), "result queue overflow")
    `EFD_ASSERT(a_esc_in_body, i_clk, i_rst_n, !r_esc || (r_pos >= POS_W'(4)), "escape outside body")
    `EFD_ASSERT_NEXT(a_frame_clear, i_clk, i_rst_n, acc && last, (r_pos == '0) && !r_esc && !r_held_valid, "frame state not cleared")
    `EFD_ASSERT_NEXT(a_qcnt_hold, i_clk, i_rst_n, !acc && !pop, $stable(r_qcnt), "queue count moved while idle")

endmodule

### tb/testbench.sv
// Self-checking testbench for escaped_frame_decoder: directed frames, then random frames.
// Depends on efd_pkg and the efd_in_if / efd_out_if channel interfaces.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import efd_pkg::*;

    localparam int N_RANDOM_ITEMS = 1150;
    localparam int TAIL_ITEMS     = 120;
    localparam int HOLD_AT_INPUT  = 400;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_END,
        FLAW_LENGTH,
        FLAW_BODY,
        FLAW_CUT
    } t_flaw;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_raw_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    efd_in_if  in_ch ();
    efd_out_if out_ch ();

    escaped_frame_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Raw bytes waiting to be offered, and results the deframer must still produce.
    t_raw_byte raw_stream[$];
    t_result   pending_results[$];
    int        queued_items;

    int inputs_accepted;
    int hold_left;
    int fail_count;

    // Deframer state as seen by the checker.
    logic [POS_W-1:0] frame_pos;
    logic             start_ok;
    logic [LEN_W-1:0] hdr_length;
    logic             esc_open;
    logic             hold_valid;
    logic [7:0]       hold_byte;
    logic [7:0]       byte_sum;
    logic [LEN_W-1:0] payload_count;

    task automatic clear_frame_state();
        frame_pos     = '0;
        start_ok      = 1'b0;
        hdr_length    = '0;
        esc_open      = 1'b0;
        hold_valid    = 1'b0;
        hold_byte     = '0;
        byte_sum      = '0;
        payload_count = '0;
    endtask

    // The previously held byte goes out as payload; the new one is held back.
    task automatic release_held(input logic [7:0] b);
        t_result r;
        if (hold_valid) begin
            r = '0;
            r.out_byte = hold_byte;
            pending_results.push_back(r);
            byte_sum = byte_sum + hold_byte;
            if (payload_count != COUNT_MAX) payload_count = payload_count + 1'b1;
        end
        hold_byte  = b;
        hold_valid = 1'b1;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic is_last);
        t_result r;
        logic    frame_ok;
        int      total;
        if (frame_pos == '0) begin
            start_ok = (b == START_BYTE);
        end else if (!is_last) begin
            if (frame_pos == 1) begin
                hdr_length = {b[7:4], 6'd0};
            end else if (frame_pos == 2) begin
                hdr_length = hdr_length | LEN_W'(b & HDR2_MASK);
            end else if (esc_open) begin
                esc_open = 1'b0;
                if (b <= ESC_MAX) begin
                    release_held(START_BYTE + b);
                end else begin
                    // not an escape code: the 0x7F passes raw
                    release_held(ESC_BYTE);
                    if (b == ESC_BYTE) esc_open = 1'b1;
                    else release_held(b);
                end
            end else if (b == ESC_BYTE) begin
                esc_open = 1'b1;
            end else begin
                release_held(b);
            end
        end

        if (!is_last) begin
            if (frame_pos != POS_MAX) frame_pos = frame_pos + 1'b1;
        end else begin
            // flush a dangling escape raw; it becomes the checksum byte
            if (esc_open) begin
                esc_open = 1'b0;
                release_held(ESC_BYTE);
            end
            total    = int'(frame_pos) + 1;
            frame_ok = (frame_pos != POS_MAX) && (total > 4) && (total == int'(hdr_length) + 4)
                       && start_ok && (b == END_BYTE);
            r = '0;
            r.out_is_status = 1'b1;
            r.out_last      = 1'b1;
            r.out_length    = payload_count;
            if (!frame_ok) r.out_status = ST_FRAMING;
            else if (!hold_valid || byte_sum != hold_byte) r.out_status = ST_CHECKSUM;
            else r.out_status = ST_OK;
            pending_results.push_back(r);
            clear_frame_state();
        end
    endtask

    // Stimulus construction.
    task automatic add_raw(input logic [7:0] b, input logic is_last);
        t_raw_byte t;
        t.data    = b;
        t.is_last = is_last;
        raw_stream.push_back(t);
        queued_items++;
    endtask

    function automatic logic [7:0] pick_payload_byte(input bit plain);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (plain) begin
            if (v >= START_BYTE && v <= ESC_BYTE) v = v ^ 8'h80;
        end else if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: v = START_BYTE;
                1: v = END_BYTE;
                2: v = ESC_BYTE;
                3: v = 8'h00;
                4: v = ESC_MAX;
                default: v = 8'hFF;
            endcase
        end
        return v;
    endfunction

    task automatic queue_frame(input int n_payload, input bit plain, input t_flaw flaw);
        logic [7:0]       decoded[$];
        logic [7:0]       body[$];
        logic [7:0]       sum;
        logic [7:0]       nxt;
        logic [7:0]       lead;
        logic [7:0]       tail;
        logic [LEN_W-1:0] len;
        bit               bare_ok;
        int               cut;
        sum = '0;
        for (int i = 0; i < n_payload; i++) begin
            decoded.push_back(pick_payload_byte(plain));
            sum = sum + decoded[i];
        end
        decoded.push_back(sum);

        foreach (decoded[i]) begin
            if (decoded[i] < START_BYTE || decoded[i] > ESC_BYTE) begin
                body.push_back(decoded[i]);
            end else begin
                // a 0x7F may go bare when the next raw byte cannot read as an escape code
                bare_ok = 1'b0;
                if (decoded[i] == ESC_BYTE) begin
                    if (i == decoded.size() - 1) begin
                        bare_ok = 1'b1;
                    end else begin
                        nxt     = decoded[i + 1];
                        bare_ok = (nxt > ESC_MAX) && (nxt < START_BYTE || nxt > ESC_BYTE);
                    end
                end
                body.push_back(ESC_BYTE);
                if (!(bare_ok && $urandom_range(0, 1) == 1)) body.push_back(decoded[i] - START_BYTE);
            end
        end

        len = LEN_W'(body.size());
        if (flaw == FLAW_LENGTH) len = len + LEN_W'($urandom_range(1, 1023));
        lead = START_BYTE;
        if (flaw == FLAW_START) lead = START_BYTE ^ 8'($urandom_range(1, 255));
        tail = END_BYTE;
        if (flaw == FLAW_END) tail = END_BYTE ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_BODY) begin
            cut       = $urandom_range(0, body.size() - 1);
            body[cut] = body[cut] ^ (8'h01 << $urandom_range(0, 7));
        end

        add_raw(lead, 1'b0);
        add_raw({len[9:6], 4'($urandom_range(0, 15))}, 1'b0);
        add_raw({2'($urandom_range(0, 3)), len[5:0]}, 1'b0);
        if (flaw == FLAW_CUT) begin
            // end the frame early, on a body byte
            cut = $urandom_range(0, body.size() - 1);
            for (int i = 0; i < cut; i++) add_raw(body[i], 1'b0);
            add_raw(body[cut], 1'b1);
        end else begin
            foreach (body[i]) add_raw(body[i], 1'b0);
            add_raw(tail, 1'b1);
        end
    endtask

    // Input driver: offers queued bytes, random idle bursts, none near the end.
    int tx_gap_left;
    int tx_idle_pct;
    int tx_mode_cycles;

    always @(posedge i_clk) begin
        t_raw_byte nxt;
        bit        tail_phase;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.in_byte   <= '0;
            in_ch.in_last   <= 1'b0;
            tx_gap_left     = 0;
            tx_idle_pct     = 0;
            tx_mode_cycles  = 0;
            inputs_accepted = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                deframe_byte(in_ch.in_byte, in_ch.in_last);
                inputs_accepted++;
            end
            if (tx_mode_cycles == 0) begin
                tx_mode_cycles = 256;
                case ($urandom_range(0, 2))
                    0: tx_idle_pct = 0;
                    1: tx_idle_pct = 8;
                    default: tx_idle_pct = 30;
                endcase
            end
            tx_mode_cycles--;
            tail_phase = raw_stream.size() < TAIL_ITEMS;

            if (!in_ch.valid || in_ch.ready) begin
                if (tx_gap_left > 0 && !tail_phase && hold_left == 0) begin
                    tx_gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (raw_stream.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (!tail_phase && hold_left == 0
                             && $urandom_range(0, 99) < tx_idle_pct) begin
                    tx_gap_left = $urandom_range(1, 14) - 1;
                    in_ch.valid <= 1'b0;
                end else begin
                    nxt = raw_stream.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= nxt.data;
                    in_ch.in_last <= nxt.is_last;
                end
            end
        end
    end

    // Output monitor: checks each transfer against the oldest expected result.
    int rx_stall_left;
    int rx_idle_pct;
    int rx_mode_cycles;
    bit hold_done;

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        bit      tail_phase;
        if (!i_rst_n) begin
            out_ch.ready   <= 1'b0;
            rx_stall_left  = 0;
            rx_idle_pct    = 0;
            rx_mode_cycles = 0;
            hold_left      = 0;
            hold_done      = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen.out_byte      = out_ch.out_byte;
                seen.out_is_status = out_ch.out_is_status;
                seen.out_status    = out_ch.out_status;
                seen.out_length    = out_ch.out_length;
                seen.out_last      = out_ch.out_last;
                if (pending_results.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result byte=%02h is_status=%0b status=%0d len=%0d last=%0b",
                                 $time, seen.out_byte, seen.out_is_status, seen.out_status,
                                 seen.out_length, seen.out_last);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        if (fail_count < MAX_REPORTS)
                            $display("%0t: mismatch byte=%02h/%02h is_status=%0b/%0b status=%0d/%0d len=%0d/%0d last=%0b/%0b (expected/actual)",
                                     $time, want.out_byte, seen.out_byte,
                                     want.out_is_status, seen.out_is_status,
                                     want.out_status, seen.out_status,
                                     want.out_length, seen.out_length,
                                     want.out_last, seen.out_last);
                        fail_count++;
                    end
                end
            end

            if (rx_mode_cycles == 0) begin
                rx_mode_cycles = 256;
                case ($urandom_range(0, 2))
                    0: rx_idle_pct = 0;
                    1: rx_idle_pct = 5;
                    default: rx_idle_pct = 20;
                endcase
            end
            rx_mode_cycles--;
            tail_phase = raw_stream.size() < TAIL_ITEMS;

            // one long hold so the result queue fills and input ready drops
            if (!hold_done && inputs_accepted >= HOLD_AT_INPUT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_stall_left > 0 && !tail_phase) begin
                rx_stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_stall_left = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles without any transfer.
    int stall_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("escaped_frame_decoder verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int frame_no;
        int kind;
        int n;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        queued_items  = 0;
        fail_count    = 0;
        clear_frame_state();

        // single-byte frame, and a frame of four bytes
        add_raw(START_BYTE, 1'b1);
        add_raw(START_BYTE, 1'b0); add_raw(8'h00, 1'b0); add_raw(8'h00, 1'b0);
        add_raw(END_BYTE, 1'b1);
        // checksum byte alone: clean frame with no payload
        add_raw(START_BYTE, 1'b0); add_raw(8'h00, 1'b0); add_raw(8'h01, 1'b0);
        add_raw(8'h00, 1'b0); add_raw(END_BYTE, 1'b1);
        // escape codes 0x00 and 0x02, raw 0x7F before a plain byte, double 0x7F, 0x7F before the end
        add_raw(START_BYTE, 1'b0); add_raw(8'h00, 1'b0); add_raw(8'h09, 1'b0);
        add_raw(ESC_BYTE, 1'b0); add_raw(8'h00, 1'b0);
        add_raw(ESC_BYTE, 1'b0); add_raw(8'h41, 1'b0);
        add_raw(8'hFF, 1'b0);
        add_raw(ESC_BYTE, 1'b0); add_raw(ESC_BYTE, 1'b0); add_raw(8'h02, 1'b0);
        add_raw(ESC_BYTE, 1'b0); add_raw(END_BYTE, 1'b1);
        // wrong start, header bytes all ones
        add_raw(8'hFF, 1'b0); add_raw(8'hFF, 1'b0); add_raw(8'hFF, 1'b0);
        add_raw(END_BYTE, 1'b1);

        frame_no = 0;
        while (queued_items < N_RANDOM_ITEMS) begin
            if (frame_no == 8) begin
                // long clean frame: length reaches the upper header nibble
                queue_frame(300, 1'b1, FLAW_NONE);
            end else begin
                kind = $urandom_range(0, 99);
                n    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
                if (kind < 60) begin
                    queue_frame(n, 1'b0, FLAW_NONE);
                end else if (kind < 85) begin
                    queue_frame(n, 1'b0, t_flaw'($urandom_range(FLAW_START, FLAW_CUT)));
                end else begin
                    n = $urandom_range(0, 12);
                    repeat (n) add_raw(8'($urandom_range(0, 255)), 1'b0);
                    add_raw(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            frame_no++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (raw_stream.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            fail_count += pending_results.size();
        end
        if (fail_count == 0) begin
            $display("escaped_frame_decoder verification clean");
        end else begin
            $display("escaped_frame_decoder verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/efd_pkg.sv
rtl/core/efd_channels.sv
rtl/core/escaped_frame_decoder.sv
tb/testbench.sv
